// ===== src/spi_flash_command_sequencer_top_defines.svh =====
// assertion macros for the flash command sequencer
`ifndef SPI_FLASH_COMMAND_SEQUENCER_TOP_DEFINES_SVH
`define SPI_FLASH_COMMAND_SEQUENCER_TOP_DEFINES_SVH
`ifndef ASSERT_OFF
// property checked at every edge outside reset
`define SFCS_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// condition in one cycle implies another in the next
`define SFCS_ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);
`else
`define SFCS_ASSERT(label, clk, rst, prop, msg)
`define SFCS_ASSERT_NEXT(label, clk, rst, pre, post, msg)
`endif
`endif

// ===== src/sfcs_pkg.sv =====
package sfcs_pkg;

   // field widths
   localparam int KindW      = 4;
   localparam int AddrW      = 32;
   localparam int LenW       = 32;
   localparam int ByteW      = 8;
   localparam int ReadCountW = 16;
   localparam int CfgW       = 3;
   localparam int OpW        = 3;

   // parameter defaults
   localparam int PageSizeDefault   = 256;
   localparam int EraseBlockDefault = 65536;

   // address_bytes register
   localparam logic [CfgW-1:0] AddrBytesReset = 3'd3;
   localparam logic [CfgW-1:0] AddrBytesFour  = 3'd4;

   // item kinds
   localparam logic [KindW-1:0] KindInit      = 4'd0;
   localparam logic [KindW-1:0] KindReadId    = 4'd1;
   localparam logic [KindW-1:0] KindRead      = 4'd2;
   localparam logic [KindW-1:0] KindProgram   = 4'd3;
   localparam logic [KindW-1:0] KindErase     = 4'd4;
   localparam logic [KindW-1:0] KindChipErase = 4'd5;
   localparam logic [KindW-1:0] KindUnprotect = 4'd6;
   localparam logic [KindW-1:0] KindPayload   = 4'd7;
   localparam logic [KindW-1:0] KindStatus    = 4'd8;

   // operations kept while busy
   localparam logic [OpW-1:0] OpProgram = 3'd3;
   localparam logic [OpW-1:0] OpErase   = 3'd4;

   // flash opcodes
   localparam logic [ByteW-1:0] OpcReadId       = 8'h9F;
   localparam logic [ByteW-1:0] OpcRead         = 8'h03;
   localparam logic [ByteW-1:0] OpcWriteEnable  = 8'h06;
   localparam logic [ByteW-1:0] OpcWriteDisable = 8'h04;
   localparam logic [ByteW-1:0] OpcPageProgram  = 8'h02;
   localparam logic [ByteW-1:0] OpcBlockErase   = 8'hD8;
   localparam logic [ByteW-1:0] OpcChipErase    = 8'hC7;
   localparam logic [ByteW-1:0] OpcReadStatus   = 8'h05;
   localparam logic [ByteW-1:0] OpcWriteStatus  = 8'h01;
   localparam logic [ByteW-1:0] OpcEnter4Byte   = 8'hB7;
   localparam logic [ByteW-1:0] StatusClear     = 8'h00;
   localparam logic [ByteW-1:0] NoByte          = 8'h00;

   // reply byte counts
   localparam logic [ReadCountW-1:0] RcNone   = 16'd0;
   localparam logic [ReadCountW-1:0] RcStatus = 16'd1;
   localparam logic [ReadCountW-1:0] RcId     = 16'd3;

   // result burst per item
   localparam int MaxResults = 6;
   localparam int CountW     = $clog2(MaxResults + 1);
   localparam int IdxW       = $clog2(MaxResults);

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_PAYLOAD,
      PH_POLL,
      PH_KICK
   } phase_type;

   typedef struct packed {
      logic                  byte_valid;
      logic [ByteW-1:0]      spi_byte;
      logic                  frame_end;
      logic [ReadCountW-1:0] read_count;
      logic                  op_done;
   } result_type;

   typedef struct packed {
      result_type [MaxResults-1:0] slot;
      logic [CountW-1:0]           count;
   } burst_type;

endpackage

// ===== src/sfcs_channels.sv =====
interface sfcs_req_if;
   import sfcs_pkg::*;
   logic             valid;
   logic             ready;
   logic [KindW-1:0] kind;
   logic [AddrW-1:0] address;
   logic [LenW-1:0]  length;
   logic [ByteW-1:0] data_byte;
   modport source (output valid, kind, address, length, data_byte, input ready);
   modport sink (input valid, kind, address, length, data_byte, output ready);
endinterface

interface sfcs_rsp_if;
   import sfcs_pkg::*;
   logic                  valid;
   logic                  ready;
   logic                  byte_valid;
   logic [ByteW-1:0]      spi_byte;
   logic                  frame_end;
   logic [ReadCountW-1:0] read_count;
   logic                  op_done;
   logic                  last;
   modport source (output valid, byte_valid, spi_byte, frame_end, read_count, op_done, last,
                   input ready);
   modport sink (input valid, byte_valid, spi_byte, frame_end, read_count, op_done, last,
                 output ready);
endinterface

interface sfcs_csr_if;
   import sfcs_pkg::*;
   logic            valid;
   logic            ready;
   logic [CfgW-1:0] address_bytes;
   modport source (output valid, address_bytes, input ready);
   modport sink (input valid, address_bytes, output ready);
endinterface

// ===== src/sfcs_engine.sv =====
module sfcs_engine #(
   parameter int PAGE_SIZE   = sfcs_pkg::PageSizeDefault,
   parameter int ERASE_BLOCK = sfcs_pkg::EraseBlockDefault
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        step,
   input  logic [sfcs_pkg::KindW-1:0]  kind,
   input  logic [sfcs_pkg::AddrW-1:0]  address,
   input  logic [sfcs_pkg::LenW-1:0]   length,
   input  logic [sfcs_pkg::ByteW-1:0]  data_byte,
   input  logic [sfcs_pkg::CfgW-1:0]   address_bytes,
   output sfcs_pkg::burst_type         burst
);
   import sfcs_pkg::*;

   // page and block sizes are powers of two
   localparam int PageBits = $clog2(PAGE_SIZE);
   localparam int ChunkW   = $clog2(PAGE_SIZE + 1);
   localparam logic [AddrW-1:0] BlockMask = ~(AddrW'(ERASE_BLOCK - 1));
   localparam logic [AddrW-1:0] BlockStep = AddrW'(ERASE_BLOCK);

   phase_type          phase_ff, phase_in;
   logic [OpW-1:0]     op_ff, op_in;
   logic [AddrW-1:0]   work_ff, work_in;
   logic [LenW-1:0]    rem_ff, rem_in;
   logic [ChunkW-1:0]  chunk_ff, chunk_in;
   logic [AddrW-1:0]   end_ff, end_in;

   logic               four;
   logic               idle;
   logic               run_chunk;
   logic               run_erase;
   logic               do_poll;
   logic [AddrW-1:0]   chunk_addr;
   logic [LenW-1:0]    chunk_rem;
   logic [AddrW-1:0]   erase_addr;
   logic [AddrW-1:0]   erase_end;
   logic [ChunkW-1:0]  room;
   burst_type          b;

   function automatic result_type mk(logic v, logic [ByteW-1:0] bt, logic fe,
                                     logic [ReadCountW-1:0] rc, logic done);
      result_type r;
      r.byte_valid = v;
      r.spi_byte   = bt;
      r.frame_end  = fe;
      r.read_count = rc;
      r.op_done    = done;
      return r;
   endfunction

   // append one result, dropped once the burst is full
   function automatic burst_type push(burst_type bi, result_type r);
      burst_type bo;
      bo = bi;
      if (bo.count < CountW'(MaxResults)) begin
         bo.slot[IdxW'(bo.count)] = r;
         bo.count = bo.count + CountW'(1);
      end
      return bo;
   endfunction

   // opcode plus 3 or 4 address bytes, frame flags on the last one
   function automatic burst_type push_header(burst_type bi, logic [ByteW-1:0] opc,
                                             logic [AddrW-1:0] a, logic wide, logic fe,
                                             logic [ReadCountW-1:0] rc, logic done);
      burst_type bo;
      bo = push(bi, mk(1'b1, opc, 1'b0, RcNone, 1'b0));
      if (wide) begin
         bo = push(bo, mk(1'b1, a[31:24], 1'b0, RcNone, 1'b0));
      end
      bo = push(bo, mk(1'b1, a[23:16], 1'b0, RcNone, 1'b0));
      bo = push(bo, mk(1'b1, a[15:8], 1'b0, RcNone, 1'b0));
      bo = push(bo, mk(1'b1, a[7:0], fe, rc, done));
      return bo;
   endfunction

   assign four = (address_bytes == AddrBytesFour);
   assign idle = (phase_ff == PH_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         op_ff    <= '0;
         work_ff  <= '0;
         rem_ff   <= '0;
         chunk_ff <= '0;
         end_ff   <= '0;
      end else if (step) begin
         phase_ff <= phase_in;
         op_ff    <= op_in;
         work_ff  <= work_in;
         rem_ff   <= rem_in;
         chunk_ff <= chunk_in;
         end_ff   <= end_in;
      end
   end

   always_comb begin
      phase_in   = phase_ff;
      op_in      = op_ff;
      work_in    = work_ff;
      rem_in     = rem_ff;
      chunk_in   = chunk_ff;
      end_in     = end_ff;
      b          = '0;
      run_chunk  = 1'b0;
      run_erase  = 1'b0;
      do_poll    = 1'b0;
      chunk_addr = work_ff;
      chunk_rem  = rem_ff;
      erase_addr = work_ff + BlockStep;
      erase_end  = end_ff;
      room       = '0;

      if (kind <= KindUnprotect && idle) begin
         op_in = kind[OpW-1:0];
      end

      unique case (kind)
         KindInit: begin
            if (idle) begin
               if (four) begin
                  b = push(b, mk(1'b1, OpcEnter4Byte, 1'b1, RcNone, 1'b1));
               end else begin
                  b = push(b, mk(1'b0, NoByte, 1'b0, RcNone, 1'b1));
               end
            end
         end
         KindReadId: begin
            if (idle) begin
               b = push(b, mk(1'b1, OpcReadId, 1'b1, RcId, 1'b1));
            end
         end
         KindRead: begin
            if (idle) begin
               b = push_header(b, OpcRead, address, four, 1'b1, length[ReadCountW-1:0], 1'b1);
            end
         end
         KindProgram: begin
            if (idle) begin
               work_in = address;
               rem_in  = length;
               if (length == '0) begin
                  b = push(b, mk(1'b1, OpcWriteDisable, 1'b1, RcNone, 1'b1));
               end else begin
                  run_chunk  = 1'b1;
                  chunk_addr = address;
                  chunk_rem  = length;
               end
            end
         end
         KindErase: begin
            if (idle) begin
               if (length == '0) begin
                  b = push(b, mk(1'b0, NoByte, 1'b0, RcNone, 1'b1));
               end else begin
                  run_erase  = 1'b1;
                  erase_addr = address & BlockMask;
                  erase_end  = address + length;
                  end_in     = erase_end;
               end
            end
         end
         KindChipErase: begin
            if (idle) begin
               b = push(b, mk(1'b1, OpcWriteEnable, 1'b1, RcNone, 1'b0));
               b = push(b, mk(1'b1, OpcChipErase, 1'b1, RcNone, 1'b0));
               do_poll = 1'b1;
            end
         end
         KindUnprotect: begin
            if (idle) begin
               b = push(b, mk(1'b1, OpcWriteEnable, 1'b1, RcNone, 1'b0));
               b = push(b, mk(1'b1, OpcWriteStatus, 1'b0, RcNone, 1'b0));
               b = push(b, mk(1'b1, StatusClear, 1'b1, RcNone, 1'b0));
               do_poll = 1'b1;
            end
         end
         KindPayload: begin
            if (phase_ff == PH_PAYLOAD) begin
               chunk_in = chunk_ff - ChunkW'(1);
               rem_in   = rem_ff - LenW'(1);
               work_in  = work_ff + AddrW'(1);
               if (chunk_in == '0) begin
                  b = push(b, mk(1'b1, data_byte, 1'b1, RcNone, 1'b0));
                  do_poll = 1'b1;
               end else begin
                  b = push(b, mk(1'b1, data_byte, 1'b0, RcNone, 1'b0));
               end
            end
         end
         KindStatus: begin
            priority if (phase_ff == PH_KICK) begin
               do_poll = 1'b1;
            end else if (phase_ff == PH_POLL) begin
               priority if (data_byte[0]) begin
                  do_poll = 1'b1;
               end else if (op_ff == OpProgram) begin
                  if (rem_ff == '0) begin
                     b = push(b, mk(1'b1, OpcWriteDisable, 1'b1, RcNone, 1'b1));
                     phase_in = PH_IDLE;
                  end else begin
                     run_chunk = 1'b1;
                  end
               end else if (op_ff == OpErase) begin
                  run_erase = 1'b1;
               end else begin
                  b = push(b, mk(1'b0, NoByte, 1'b0, RcNone, 1'b1));
                  phase_in = PH_IDLE;
               end
            end else begin
               // stray status reply, dropped
            end
         end
         default: begin
         end
      endcase

      // write enable and page program header for the next chunk, cut at the page end
      if (run_chunk) begin
         room = ChunkW'(PAGE_SIZE) - ChunkW'(chunk_addr[PageBits-1:0]);
         chunk_in = (chunk_rem < LenW'(room)) ? chunk_rem[ChunkW-1:0] : room;
         b = push(b, mk(1'b1, OpcWriteEnable, 1'b1, RcNone, 1'b0));
         b = push_header(b, OpcPageProgram, chunk_addr, four, 1'b0, RcNone, 1'b0);
         phase_in = PH_PAYLOAD;
      end

      // next block erase, or done once at or past the end address
      if (run_erase) begin
         work_in = erase_addr;
         if (erase_addr < erase_end) begin
            b = push(b, mk(1'b1, OpcWriteEnable, 1'b1, RcNone, 1'b0));
            b = push_header(b, OpcBlockErase, erase_addr, four, 1'b1, RcNone, 1'b0);
            do_poll = 1'b1;
         end else begin
            b = push(b, mk(1'b0, NoByte, 1'b0, RcNone, 1'b1));
            phase_in = PH_IDLE;
         end
      end

      // status poll, held for the next status item when the burst is full
      if (do_poll) begin
         if (b.count < CountW'(MaxResults)) begin
            b = push(b, mk(1'b1, OpcReadStatus, 1'b1, RcStatus, 1'b0));
            phase_in = PH_POLL;
         end else begin
            phase_in = PH_KICK;
         end
      end
   end

   assign burst = b;

endmodule

// ===== src/spi_flash_command_sequencer_top.sv =====
// SPI NOR flash command sequencer
//
// req_chan carries requests (init, read id, read, program, erase range,
// chip erase, unprotect), program payload bytes and status replies. rsp_chan
// returns the command, address and payload bytes for the flash, each with
// frame end, the reply byte count and an op done flag; last marks the final
// result of an item. csr_chan writes address_bytes (3 or 4), always ready;
// the user must write it only while the block is idle; nothing enforces it.
//
// an item is registered at its accept edge and turned into a burst of zero
// to six results, loaded into the burst buffer once the buffer is free.
// results leave one per cycle from the burst buffer while the receiver is
// ready. items with at most one result flow at one per cycle when the
// receiver does not stall; a longer item holds the buffer until all leave.
// when the receiver stalls, the burst buffer holds, then the input register
// fills and req ready drops; nothing is lost.
// reset clears the sequencer to idle, empties both stages and sets
// address_bytes to 3.
`include "spi_flash_command_sequencer_top_defines.svh"

module spi_flash_command_sequencer_top #(
   parameter int PAGE_SIZE   = sfcs_pkg::PageSizeDefault,
   parameter int ERASE_BLOCK = sfcs_pkg::EraseBlockDefault
) (
   input  logic        clock,
   input  logic        reset,
   sfcs_req_if.sink    req_chan,
   sfcs_rsp_if.source  rsp_chan,
   sfcs_csr_if.sink    csr_chan
);
   import sfcs_pkg::*;

   // input register
   logic             in_valid_ff;
   logic [KindW-1:0] kind_ff;
   logic [AddrW-1:0] address_ff;
   logic [LenW-1:0]  length_ff;
   logic [ByteW-1:0] data_byte_ff;

   // configuration
   logic [CfgW-1:0]  addr_bytes_ff;

   // burst buffer
   result_type [MaxResults-1:0] slot_ff;
   logic [CountW-1:0]           cnt_ff;
   logic [IdxW-1:0]             idx_ff;

   logic       req_fire;
   logic       rsp_fire;
   logic       at_last;
   logic       buf_free;
   logic       advance;
   burst_type  burst;
   result_type cur;

   assign req_fire = req_chan.valid & req_chan.ready;
   assign rsp_fire = rsp_chan.valid & rsp_chan.ready;
   assign at_last  = (idx_ff == IdxW'(cnt_ff - CountW'(1)));

   // buffer takes a new burst when empty or its final result leaves now
   assign buf_free = (cnt_ff == '0) || (rsp_fire && at_last);
   assign advance  = in_valid_ff && buf_free;

   assign req_chan.ready = !in_valid_ff || advance;
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_fire) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         kind_ff      <= req_chan.kind;
         address_ff   <= req_chan.address;
         length_ff    <= req_chan.length;
         data_byte_ff <= req_chan.data_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         addr_bytes_ff <= AddrBytesReset;
      end else if (csr_chan.valid) begin
         addr_bytes_ff <= csr_chan.address_bytes;
      end
   end

   // sequencer state and per-item decode
   sfcs_engine #(
      .PAGE_SIZE   (PAGE_SIZE),
      .ERASE_BLOCK (ERASE_BLOCK)
   ) u_engine (
      .clock         (clock),
      .reset         (reset),
      .step          (advance),
      .kind          (kind_ff),
      .address       (address_ff),
      .length        (length_ff),
      .data_byte     (data_byte_ff),
      .address_bytes (addr_bytes_ff),
      .burst         (burst)
   );

   // burst buffer control
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         idx_ff <= '0;
      end else if (advance) begin
         cnt_ff <= burst.count;
         idx_ff <= '0;
      end else if (rsp_fire) begin
         if (at_last) begin
            cnt_ff <= '0;
            idx_ff <= '0;
         end else begin
            idx_ff <= idx_ff + IdxW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         slot_ff <= burst.slot;
      end
   end

   assign cur = slot_ff[idx_ff];

   assign rsp_chan.valid      = (cnt_ff != '0);
   assign rsp_chan.byte_valid = cur.byte_valid;
   assign rsp_chan.spi_byte   = cur.spi_byte;
   assign rsp_chan.frame_end  = cur.frame_end;
   assign rsp_chan.read_count = cur.read_count;
   assign rsp_chan.op_done    = cur.op_done;
   assign rsp_chan.last       = at_last;

   // read position never runs past the burst
   `SFCS_ASSERT(a_idx_in_burst, clock, reset, (cnt_ff != '0) |-> (idx_ff < IdxW'(cnt_ff)), "burst index past count")
   // a result that is not last leaves more behind it
   `SFCS_ASSERT_NEXT(a_more_after_not_last, clock, reset, rsp_fire && !rsp_chan.last, rsp_chan.valid, "burst ended early")
   // an accepted item always lands in the input register
   `SFCS_ASSERT_NEXT(a_item_held, clock, reset, req_fire, in_valid_ff, "accepted item lost")
   // results without a byte carry no byte and no frame end
   `SFCS_ASSERT(a_empty_result, clock, reset, (rsp_chan.valid && !rsp_chan.byte_valid) |-> (rsp_chan.spi_byte == NoByte && !rsp_chan.frame_end), "empty result carries data")

endmodule

// ===== bench/spi_flash_command_sequencer_top_test.sv =====
`timescale 1ns / 1ps

module spi_flash_command_sequencer_top_test;
   import sfcs_pkg::*;

   // row and stall controls
   localparam int Predicted     = -1;
   localparam int NoResult      = 0;
   localparam int OneResult     = 1;
   localparam int SettleCycles  = 8;
   localparam int HoldOffCycles = 400;
   localparam int WatchdogLimit = 2000;
   localparam int PhaseItems    = 100;

   // kinds above status are never decoded
   localparam logic [KindW-1:0] KindUnused = 4'd15;

   localparam logic [AddrW-1:0] PageBytes  = PageSizeDefault;
   localparam logic [AddrW-1:0] EraseBytes = EraseBlockDefault;

   typedef struct packed {
      logic [KindW-1:0] kind;
      logic [AddrW-1:0] address;
      logic [LenW-1:0]  length;
      logic [ByteW-1:0] data_byte;
   } flash_request_type;

   typedef struct packed {
      result_type body;
      logic       last;
   } flash_result_type;

   // one step of the directed sequence; typed rows carry their own result
   typedef struct {
      bit                csr;
      flash_request_type request;
      int                typed;
      result_type        result;
   } directed_row_type;

   logic clock = 1'b0;
   logic reset;

   sfcs_req_if req_chan ();
   sfcs_rsp_if rsp_chan ();
   sfcs_csr_if csr_chan ();

   spi_flash_command_sequencer_top i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // sequencer mirror: configuration and operation state
   // ------------------------------------------------------------------
   logic [CfgW-1:0]  addr_bytes_q  = AddrBytesReset;
   phase_type        seq_phase     = PH_IDLE;
   logic [OpW-1:0]   seq_op        = '0;
   logic [AddrW-1:0] seq_address   = '0;
   logic [LenW-1:0]  seq_remaining = '0;
   logic [8:0]       seq_chunk     = '0;
   logic [AddrW-1:0] seq_end       = '0;

   // bytes caused by the item in hand, then everything still owed by the block
   flash_result_type burst [$];
   flash_result_type expected_results [$];

   int mismatches      = 0;
   int req_idle_pct    = 0;
   int rsp_stall_pct   = 0;
   bit rsp_hold_pending = 1'b0;

   // a burst never grows past six bytes; extra ones are dropped
   function automatic void queue_spi_byte(logic v, logic [ByteW-1:0] b, logic fe,
                                          logic [ReadCountW-1:0] rc, logic done);
      flash_result_type r;
      if (burst.size() >= MaxResults) return;
      r.body.byte_valid = v;
      r.body.spi_byte   = b;
      r.body.frame_end  = fe;
      r.body.read_count = rc;
      r.body.op_done    = done;
      r.last            = 1'b0;
      burst.push_back(r);
   endfunction

   // opcode then 3 or 4 address bytes, msb first
   function automatic void queue_header(logic [ByteW-1:0] opc, logic [AddrW-1:0] addr,
                                        logic fe, logic [ReadCountW-1:0] rc);
      queue_spi_byte(1'b1, opc, 1'b0, RcNone, 1'b0);
      if (addr_bytes_q == AddrBytesFour) queue_spi_byte(1'b1, addr[31:24], 1'b0, RcNone, 1'b0);
      queue_spi_byte(1'b1, addr[23:16], 1'b0, RcNone, 1'b0);
      queue_spi_byte(1'b1, addr[15:8], 1'b0, RcNone, 1'b0);
      queue_spi_byte(1'b1, addr[7:0], fe, fe ? rc : RcNone, 1'b0);
   endfunction

   // no room left in the burst: the poll waits for the next status item
   function automatic void queue_status_poll();
      if (burst.size() < MaxResults) begin
         queue_spi_byte(1'b1, OpcReadStatus, 1'b1, RcStatus, 1'b0);
         seq_phase = PH_POLL;
      end else begin
         seq_phase = PH_KICK;
      end
   endfunction

   function automatic void queue_op_done();
      queue_spi_byte(1'b0, NoByte, 1'b0, RcNone, 1'b1);
      seq_phase = PH_IDLE;
   endfunction

   // chunk stops at the page boundary or at the end of the data
   function automatic void open_page_chunk();
      logic [AddrW-1:0] room;
      room = PageBytes - (seq_address % PageBytes);
      seq_chunk = (seq_remaining < room) ? seq_remaining[8:0] : room[8:0];
      queue_spi_byte(1'b1, OpcWriteEnable, 1'b1, RcNone, 1'b0);
      queue_header(OpcPageProgram, seq_address, 1'b0, RcNone);
      seq_phase = PH_PAYLOAD;
   endfunction

   function automatic void erase_next_block();
      if (seq_address < seq_end) begin
         queue_spi_byte(1'b1, OpcWriteEnable, 1'b1, RcNone, 1'b0);
         queue_header(OpcBlockErase, seq_address, 1'b1, RcNone);
         queue_status_poll();
      end else begin
         queue_op_done();
      end
   endfunction

   // advances the mirror by one accepted item and leaves its bytes in burst
   function automatic void advance_sequencer(flash_request_type it);
      flash_result_type r;
      burst.delete();
      if (it.kind <= KindUnprotect) begin
         if (seq_phase != PH_IDLE) return;
         seq_op = it.kind[OpW-1:0];
         case (it.kind)
            KindInit: begin
               if (addr_bytes_q == AddrBytesFour)
                  queue_spi_byte(1'b1, OpcEnter4Byte, 1'b1, RcNone, 1'b1);
               else
                  queue_spi_byte(1'b0, NoByte, 1'b0, RcNone, 1'b1);
            end
            KindReadId: queue_spi_byte(1'b1, OpcReadId, 1'b1, RcId, 1'b1);
            KindRead: begin
               queue_header(OpcRead, it.address, 1'b1, it.length[ReadCountW-1:0]);
               r = burst.pop_back();
               r.body.op_done = 1'b1;
               burst.push_back(r);
            end
            KindProgram: begin
               seq_address   = it.address;
               seq_remaining = it.length;
               if (it.length == '0)
                  queue_spi_byte(1'b1, OpcWriteDisable, 1'b1, RcNone, 1'b1);
               else
                  open_page_chunk();
            end
            KindErase: begin
               if (it.length == '0) begin
                  queue_op_done();
               end else begin
                  seq_end     = it.address + it.length;
                  seq_address = it.address - (it.address % EraseBytes);
                  erase_next_block();
               end
            end
            KindChipErase: begin
               queue_spi_byte(1'b1, OpcWriteEnable, 1'b1, RcNone, 1'b0);
               queue_spi_byte(1'b1, OpcChipErase, 1'b1, RcNone, 1'b0);
               queue_status_poll();
            end
            default: begin
               // unprotect: clear the status register
               queue_spi_byte(1'b1, OpcWriteEnable, 1'b1, RcNone, 1'b0);
               queue_spi_byte(1'b1, OpcWriteStatus, 1'b0, RcNone, 1'b0);
               queue_spi_byte(1'b1, StatusClear, 1'b1, RcNone, 1'b0);
               queue_status_poll();
            end
         endcase
      end else if (it.kind == KindPayload) begin
         if (seq_phase != PH_PAYLOAD) return;
         seq_chunk     = seq_chunk - 9'd1;
         seq_remaining = seq_remaining - LenW'(1);
         seq_address   = seq_address + AddrW'(1);
         if (seq_chunk == '0) begin
            queue_spi_byte(1'b1, it.data_byte, 1'b1, RcNone, 1'b0);
            queue_status_poll();
         end else begin
            queue_spi_byte(1'b1, it.data_byte, 1'b0, RcNone, 1'b0);
         end
      end else if (it.kind == KindStatus) begin
         if (seq_phase == PH_KICK) begin
            // held-back poll goes out now, reply byte ignored
            queue_status_poll();
         end else if (seq_phase == PH_POLL) begin
            if (it.data_byte[0]) begin
               queue_spi_byte(1'b1, OpcReadStatus, 1'b1, RcStatus, 1'b0);
            end else if (seq_op == OpProgram) begin
               if (seq_remaining == '0) begin
                  queue_spi_byte(1'b1, OpcWriteDisable, 1'b1, RcNone, 1'b1);
                  seq_phase = PH_IDLE;
               end else begin
                  open_page_chunk();
               end
            end else if (seq_op == OpErase) begin
               seq_address = seq_address + EraseBytes;
               erase_next_block();
            end else begin
               queue_op_done();
            end
         end
      end
      if (burst.size() > 0) begin
         r = burst.pop_back();
         r.last = 1'b1;
         burst.push_back(r);
      end
   endfunction

   // ------------------------------------------------------------------
   // request side
   // ------------------------------------------------------------------

   // valid stays high from one item to the next unless an idle cycle is rolled
   task automatic send_item(input flash_request_type it, input int typed,
                            input result_type typed_result, output int produced);
      flash_result_type r;
      while ($urandom_range(99) < req_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid     <= 1'b1;
      req_chan.kind      <= it.kind;
      req_chan.address   <= it.address;
      req_chan.length    <= it.length;
      req_chan.data_byte <= it.data_byte;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      advance_sequencer(it);
      produced = burst.size();
      if (typed == Predicted) begin
         foreach (burst[i]) expected_results.push_back(burst[i]);
      end else if (typed == OneResult) begin
         r.body = typed_result;
         r.last = 1'b1;
         expected_results.push_back(r);
      end
   endtask

   // stop offering, let every owed byte come back, then let the pipe settle
   task automatic wait_drained();
      req_chan.valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   // feeds payload and ready status until the sequencer is back in idle
   task automatic finish_flash_operation();
      flash_request_type it;
      int                produced;
      while (seq_phase != PH_IDLE) begin
         it           = '0;
         it.data_byte = ByteW'($urandom());
         if (seq_phase == PH_PAYLOAD) begin
            it.kind = KindPayload;
         end else begin
            it.kind         = KindStatus;
            it.data_byte[0] = 1'b0;
         end
         send_item(it, Predicted, '0, produced);
      end
   endtask

   // register writes only with the sequencer idle and nothing in flight
   task automatic write_address_bytes(input logic [CfgW-1:0] value);
      finish_flash_operation();
      wait_drained();
      csr_chan.valid         <= 1'b1;
      csr_chan.address_bytes <= value;
      @(posedge clock);
      while (!csr_chan.ready) @(posedge clock);
      csr_chan.valid <= 1'b0;
      addr_bytes_q = value;
   endtask

   // mostly complete operations with random content, some ignored noise
   task automatic run_random_phase(input int target);
      flash_request_type it;
      int                produced;
      int                sel;
      int                busy_items;
      busy_items = 0;
      while (busy_items < target) begin
         it.kind      = KindStatus;
         it.address   = $urandom();
         it.length    = $urandom();
         it.data_byte = ByteW'($urandom());
         sel          = $urandom_range(99);
         if (seq_phase == PH_IDLE) begin
            if (sel < 8) begin
               // payload, status and unused kinds are all dropped while idle
               it.kind = KindW'($urandom_range(15, 7));
            end else if (sel < 40) begin
               it.kind = KindProgram;
               case ($urandom_range(9))
                  0: it.length = '0;
                  1: it.length = $urandom_range(300, 1);
                  default: it.length = $urandom_range(40, 1);
               endcase
            end else if (sel < 58) begin
               it.kind = KindErase;
               case ($urandom_range(9))
                  0: it.length = '0;
                  1: begin
                     // top of memory, end wraps below the first block
                     it.address = 32'hFFFF_0000 | $urandom_range(16'hFFFF);
                     it.length  = $urandom_range(32'h0003_0000, 32'h0001_0000);
                  end
                  default: begin
                     it.address = $urandom_range(32'hFFEF_FFFF);
                     it.length  = $urandom_range(32'h0003_0000, 1);
                  end
               endcase
            end else if (sel < 72) begin
               it.kind = KindRead;
            end else if (sel < 79) begin
               it.kind = KindReadId;
            end else if (sel < 85) begin
               it.kind = KindInit;
            end else if (sel < 92) begin
               it.kind = KindChipErase;
            end else begin
               it.kind = KindUnprotect;
            end
         end else if (seq_phase == PH_PAYLOAD) begin
            if (sel < 6) begin
               it.kind = KindW'($urandom_range(15));
               if (it.kind == KindPayload) it.kind = KindUnused;
            end else begin
               it.kind = KindPayload;
            end
         end else begin
            if (sel < 6) begin
               it.kind = KindW'($urandom_range(15));
               if (it.kind == KindStatus) it.kind = KindUnused;
            end else begin
               // flash reports busy about a quarter of the time
               it.kind         = KindStatus;
               it.data_byte[0] = ($urandom_range(99) < 25);
            end
         end
         send_item(it, Predicted, '0, produced);
         if (produced > 0) busy_items++;
      end
   endtask

   // ------------------------------------------------------------------
   // directed sequence: ignored items, extremes, every operation, both modes
   // ------------------------------------------------------------------
   directed_row_type directed_rows [30] = '{
      // nothing decoded while idle
      '{1'b0, {KindStatus, 32'h0000_0000, 32'h0000_0000, 8'h00}, NoResult, '0},
      '{1'b0, {KindPayload, 32'h0000_0000, 32'h0000_0000, 8'h5A}, NoResult, '0},
      '{1'b0, {KindUnused, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF}, NoResult, '0},
      // 3-byte init sends nothing
      '{1'b0, {KindInit, 32'h0000_0000, 32'h0000_0000, 8'h00}, OneResult,
        {1'b0, NoByte, 1'b0, RcNone, 1'b1}},
      '{1'b0, {KindReadId, 32'h0000_0000, 32'h0000_0000, 8'h00}, OneResult,
        {1'b1, OpcReadId, 1'b1, RcId, 1'b1}},
      // read count is the low half of the length
      '{1'b0, {KindRead, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'h00}, Predicted, '0},
      // empty program is write disable alone
      '{1'b0, {KindProgram, 32'h0000_1234, 32'h0000_0000, 8'h00}, OneResult,
        {1'b1, OpcWriteDisable, 1'b1, RcNone, 1'b1}},
      // program across a page boundary, busy once, request while busy
      '{1'b0, {KindProgram, 32'h0000_01FE, 32'h0000_0003, 8'h00}, Predicted, '0},
      '{1'b0, {KindPayload, 32'h0000_0000, 32'h0000_0000, 8'hA5}, Predicted, '0},
      '{1'b0, {KindPayload, 32'h0000_0000, 32'h0000_0000, 8'h5A}, Predicted, '0},
      '{1'b0, {KindChipErase, 32'h0000_0000, 32'h0000_0000, 8'h00}, NoResult, '0},
      '{1'b0, {KindStatus, 32'h0000_0000, 32'h0000_0000, 8'h01}, Predicted, '0},
      '{1'b0, {KindStatus, 32'h0000_0000, 32'h0000_0000, 8'hFE}, Predicted, '0},
      '{1'b0, {KindPayload, 32'h0000_0000, 32'h0000_0000, 8'hFF}, Predicted, '0},
      '{1'b0, {KindStatus, 32'h0000_0000, 32'h0000_0000, 8'h00}, Predicted, '0},
      // erase range over two blocks
      '{1'b0, {KindErase, 32'h0001_2345, 32'h0001_0000, 8'h00}, Predicted, '0},
      '{1'b0, {KindStatus, 32'h0000_0000, 32'h0000_0000, 8'h00}, Predicted, '0},
      '{1'b0, {KindStatus, 32'h0000_0000, 32'h0000_0000, 8'h00}, Predicted, '0},
      '{1'b0, {KindErase, 32'h00AB_CDEF, 32'h0000_0000, 8'h00}, OneResult,
        {1'b0, NoByte, 1'b0, RcNone, 1'b1}},
      '{1'b0, {KindChipErase, 32'h0000_0000, 32'h0000_0000, 8'h00}, Predicted, '0},
      '{1'b0, {KindStatus, 32'h0000_0000, 32'h0000_0000, 8'h00}, Predicted, '0},
      '{1'b0, {KindUnprotect, 32'h0000_0000, 32'h0000_0000, 8'h00}, Predicted, '0},
      '{1'b0, {KindStatus, 32'h0000_0000, 32'h0000_0000, 8'h00}, Predicted, '0},
      // switch to 4-byte addresses
      '{1'b1, {KindInit, 32'h0000_0000, 32'h0000_0000, {5'd0, AddrBytesFour}}, NoResult, '0},
      '{1'b0, {KindInit, 32'h0000_0000, 32'h0000_0000, 8'h00}, OneResult,
        {1'b1, OpcEnter4Byte, 1'b1, RcNone, 1'b1}},
      // block erase fills the burst, poll held for the next status
      '{1'b0, {KindErase, 32'hFFFE_0000, 32'h0000_0001, 8'h00}, Predicted, '0},
      '{1'b0, {KindStatus, 32'h0000_0000, 32'h0000_0000, 8'hFF}, Predicted, '0},
      '{1'b0, {KindStatus, 32'h0000_0000, 32'h0000_0000, 8'h00}, Predicted, '0},
      '{1'b0, {KindRead, 32'h0000_0000, 32'h0000_0000, 8'h00}, Predicted, '0},
      // end address wraps below the first block, nothing to erase
      '{1'b0, {KindErase, 32'hFFFF_8000, 32'h0001_0000, 8'h00}, OneResult,
        {1'b0, NoByte, 1'b0, RcNone, 1'b1}}
   };

   // ------------------------------------------------------------------
   // result side: random stalls, one long hold-off on request
   // ------------------------------------------------------------------
   task automatic compare_field(input string name, input int unsigned want,
                                input int unsigned got);
      if (want != got) begin
         mismatches++;
         $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
      end
   endtask

   task automatic check_result();
      flash_result_type want;
      if (expected_results.size() == 0) begin
         mismatches++;
         $display("%0t: result with none expected, actual byte_valid %0b spi_byte %0h last %0b",
                  $time, rsp_chan.byte_valid, rsp_chan.spi_byte, rsp_chan.last);
      end else begin
         want = expected_results.pop_front();
         compare_field("byte_valid", want.body.byte_valid, rsp_chan.byte_valid);
         compare_field("spi_byte", want.body.spi_byte, rsp_chan.spi_byte);
         compare_field("frame_end", want.body.frame_end, rsp_chan.frame_end);
         compare_field("read_count", want.body.read_count, rsp_chan.read_count);
         compare_field("op_done", want.body.op_done, rsp_chan.op_done);
         compare_field("last", want.last, rsp_chan.last);
      end
   endtask

   initial begin
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_chan.valid && rsp_chan.ready) check_result();
         if (rsp_hold_pending) begin
            // long stall so the burst buffer and input stage both fill
            rsp_hold_pending = 1'b0;
            rsp_chan.ready <= 1'b0;
            repeat (HoldOffCycles) @(posedge clock);
         end else begin
            rsp_chan.ready <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   // ------------------------------------------------------------------
   // watchdog: too long without any handshake on any channel
   // ------------------------------------------------------------------
   int quiet_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready) ||
          (csr_chan.valid && csr_chan.ready))
         quiet_cycles = 0;
      else
         quiet_cycles = quiet_cycles + 1;
      if (quiet_cycles >= WatchdogLimit) begin
         $display("spi_flash_command_sequencer_top regression: fail");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // main sequence
   // ------------------------------------------------------------------
   initial begin
      int produced;
      reset                  <= 1'b1;
      req_chan.valid         <= 1'b0;
      req_chan.kind          <= KindInit;
      req_chan.address       <= '0;
      req_chan.length        <= '0;
      req_chan.data_byte     <= '0;
      csr_chan.valid         <= 1'b0;
      csr_chan.address_bytes <= AddrBytesReset;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // sender idles lightly, receiver heavily
      req_idle_pct  = 21;
      rsp_stall_pct = 57;
      foreach (directed_rows[i]) begin
         if (directed_rows[i].csr)
            write_address_bytes(directed_rows[i].request.data_byte[CfgW-1:0]);
         else
            send_item(directed_rows[i].request, directed_rows[i].typed,
                      directed_rows[i].result, produced);
      end

      // all-ones register value still means 3-byte addresses
      write_address_bytes(3'd7);
      run_random_phase(PhaseItems);

      // roles swapped
      req_idle_pct  = 57;
      rsp_stall_pct = 21;
      write_address_bytes(AddrBytesFour);
      run_random_phase(PhaseItems);

      // no idling, plus the long receiver hold-off
      req_idle_pct  = 0;
      rsp_stall_pct = 0;
      write_address_bytes(3'd0);
      rsp_hold_pending = 1'b1;
      run_random_phase(PhaseItems);

      wait_drained();
      if (mismatches == 0)
         $display("spi_flash_command_sequencer_top regression: pass");
      else
         $display("spi_flash_command_sequencer_top regression: fail");
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+src
src/sfcs_pkg.sv
src/sfcs_channels.sv
src/sfcs_engine.sv
src/spi_flash_command_sequencer_top.sv
bench/spi_flash_command_sequencer_top_test.sv
